// ===== rtl/directed_graph_cycle_detect_defines.svh =====
// ============================================================================
// Directed graph cycle detector - assertion macros
// Shared property wrappers for the checker of the cycle detector.
// ============================================================================
`ifndef DIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH
`define DIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dgcd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dgcd check failed: next-cycle implication");

`endif

// ===== rtl/dgcd_pkg.sv =====
// ============================================================================
// dgcd_pkg
// Types, codes and the microprogram of the directed graph cycle detector.
// ============================================================================
package dgcd_pkg;

    // Fixed field widths of the beat payload
    localparam int VERT_W  = 6;
    localparam int COUNT_W = 7;

    // Vertex colours
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GREY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;

    // Step addresses of the microprogram
    typedef logic [2:0] t_pc;
    localparam t_pc PC_IDLE      = 3'd0;
    localparam t_pc PC_ROOT_RD   = 3'd1;
    localparam t_pc PC_ROOT_OPEN = 3'd2;
    localparam t_pc PC_SCAN      = 3'd3;
    localparam t_pc PC_EDGE      = 3'd4;
    localparam t_pc PC_POP       = 3'd5;
    localparam t_pc PC_RESTORE   = 3'd6;
    localparam t_pc PC_DONE      = 3'd7;

    // Datapath micro-operations
    typedef logic [2:0] t_act;
    localparam t_act ACT_IDLE      = 3'd0;
    localparam t_act ACT_ROOT_RD   = 3'd1;
    localparam t_act ACT_ROOT_OPEN = 3'd2;
    localparam t_act ACT_SCAN      = 3'd3;
    localparam t_act ACT_EDGE      = 3'd4;
    localparam t_act ACT_POP       = 3'd5;
    localparam t_act ACT_RESTORE   = 3'd6;
    localparam t_act ACT_DONE      = 3'd7;

    // Jump conditions
    typedef logic [3:0] t_cond;
    localparam t_cond COND_NEVER     = 4'd0;
    localparam t_cond COND_EVAL      = 4'd1;
    localparam t_cond COND_ROOT_END  = 4'd2;
    localparam t_cond COND_NOT_WHITE = 4'd3;
    localparam t_cond COND_SCAN_END  = 4'd4;
    localparam t_cond COND_NO_EDGE   = 4'd5;
    localparam t_cond COND_WHITE     = 4'd6;
    localparam t_cond COND_LAST      = 4'd7;
    localparam t_cond COND_OUT_BUSY  = 4'd8;

    // One control word: operation, then two prioritized jumps, else fall to tgt_f
    typedef struct packed {
        t_act  act;
        t_cond cond_a;
        t_pc   tgt_a;
        t_cond cond_b;
        t_pc   tgt_b;
        t_pc   tgt_f;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic eval;
        logic root_end;
        logic not_white;
        logic scan_end;
        logic no_edge;
        logic white;
        logic last;
        logic out_busy;
    } t_stat;

    // Control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        case (pc)
            PC_IDLE:      uw = '{ACT_IDLE,      COND_EVAL,      PC_ROOT_RD,
                                 COND_NEVER,    PC_IDLE,        PC_IDLE};
            PC_ROOT_RD:   uw = '{ACT_ROOT_RD,   COND_ROOT_END,  PC_DONE,
                                 COND_NEVER,    PC_IDLE,        PC_ROOT_OPEN};
            PC_ROOT_OPEN: uw = '{ACT_ROOT_OPEN, COND_NOT_WHITE, PC_ROOT_RD,
                                 COND_NEVER,    PC_IDLE,        PC_SCAN};
            PC_SCAN:      uw = '{ACT_SCAN,      COND_SCAN_END,  PC_POP,
                                 COND_NO_EDGE,  PC_SCAN,        PC_EDGE};
            PC_EDGE:      uw = '{ACT_EDGE,      COND_WHITE,     PC_SCAN,
                                 COND_NEVER,    PC_IDLE,        PC_SCAN};
            PC_POP:       uw = '{ACT_POP,       COND_LAST,      PC_ROOT_RD,
                                 COND_NEVER,    PC_IDLE,        PC_RESTORE};
            PC_RESTORE:   uw = '{ACT_RESTORE,   COND_NEVER,     PC_IDLE,
                                 COND_NEVER,    PC_IDLE,        PC_SCAN};
            PC_DONE:      uw = '{ACT_DONE,      COND_OUT_BUSY,  PC_DONE,
                                 COND_NEVER,    PC_IDLE,        PC_IDLE};
            default:      uw = '{ACT_IDLE,      COND_NEVER,     PC_IDLE,
                                 COND_NEVER,    PC_IDLE,        PC_IDLE};
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/dgcd_useq.sv =====
// ============================================================================
// dgcd_useq
// Microprogram sequencer: step counter, control store and jump selection.
// ============================================================================
module dgcd_useq
    import dgcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stat  i_stat,
    output t_uword o_ctrl
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;

    function automatic logic cond_true(input t_cond c, input t_stat s);
        logic res;
        case (c)
            COND_NEVER:     res = 1'b0;
            COND_EVAL:      res = s.eval;
            COND_ROOT_END:  res = s.root_end;
            COND_NOT_WHITE: res = s.not_white;
            COND_SCAN_END:  res = s.scan_end;
            COND_NO_EDGE:   res = s.no_edge;
            COND_WHITE:     res = s.white;
            COND_LAST:      res = s.last;
            COND_OUT_BUSY:  res = s.out_busy;
            default:        res = 1'b0;
        endcase
        return res;
    endfunction

    assign w_uw   = ucode(r_pc);
    assign o_ctrl = w_uw;

    always_comb begin
        if (cond_true(w_uw.cond_a, i_stat)) begin
            n_pc = w_uw.tgt_a;
        end else if (cond_true(w_uw.cond_b, i_stat)) begin
            n_pc = w_uw.tgt_b;
        end else begin
            n_pc = w_uw.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/dgcd_dpath.sv =====
// ============================================================================
// dgcd_dpath
// Datapath: adjacency, colour and stack memories, walk registers, result.
// ============================================================================
module dgcd_dpath
    import dgcd_pkg::*;
#(
    parameter int NUM_V = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_uword             i_ctrl,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [VERT_W-1:0]  i_src,
    input  logic [VERT_W-1:0]  i_dst,
    input  logic [COUNT_W-1:0] i_vertex_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_has_cycle,
    output t_stat              o_stat
);

    localparam int VW = (NUM_V > 1) ? $clog2(NUM_V) : 1;
    localparam int CW = $clog2(NUM_V + 1);
    localparam int SW = VW + CW;
    localparam logic [COUNT_W-1:0] NV_CNT = COUNT_W'(NUM_V);

    // Memories
    logic [NUM_V-1:0] r_adj [NUM_V];
    logic [1:0]       r_col [NUM_V];
    logic [SW-1:0]    r_stk [NUM_V];

    logic [NUM_V-1:0] r_adj_vld, n_adj_vld;
    logic [NUM_V-1:0] r_col_vld, n_col_vld;
    logic [NUM_V-1:0] r_adj_rd;
    logic             r_adj_rd_vld;
    logic [1:0]       r_col_rd;
    logic             r_col_rd_vld;
    logic [SW-1:0]    r_stk_rd;

    // Walk registers
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_root, n_root;
    logic [CW-1:0] r_depth, n_depth;
    logic [VW-1:0] r_v, n_v;
    logic [CW-1:0] r_i, n_i;
    logic          r_found, n_found;
    logic          r_out_valid, n_out_valid;
    logic          r_has_cycle, n_has_cycle;

    // Memory port controls
    logic          adj_we, adj_re;
    logic [VW-1:0] adj_ra;
    logic          col_we, col_re;
    logic [VW-1:0] col_wa, col_ra;
    logic [1:0]    col_wd;
    logic          stk_we, stk_re;
    logic [VW-1:0] stk_wa, stk_ra;
    logic [SW-1:0] stk_wd;

    logic               w_acc;
    logic               w_edge_ok;
    logic [COUNT_W-1:0] w_cnt_sat;
    logic [NUM_V-1:0]   w_row;
    logic               w_row_bit;
    logic [1:0]         w_colour;
    logic [CW-1:0]      w_depth_m1;
    logic [CW-1:0]      w_depth_m2;
    logic [CW-1:0]      w_i_p1;
    logic [NUM_V-1:0]   w_onehot;

    assign o_in_ready  = (i_ctrl.act == ACT_IDLE);
    assign w_acc       = i_in_valid & o_in_ready;
    assign w_edge_ok   = ({1'b0, i_src} < NV_CNT) && ({1'b0, i_dst} < NV_CNT);
    assign w_cnt_sat   = (i_vertex_count > NV_CNT) ? NV_CNT : i_vertex_count;
    assign w_row       = r_adj_rd_vld ? r_adj_rd : '0;
    assign w_row_bit   = w_row[r_i[VW-1:0]];
    assign w_colour    = r_col_rd_vld ? r_col_rd : COL_WHITE;
    assign w_depth_m1  = r_depth - CW'(1);
    assign w_depth_m2  = r_depth - CW'(2);
    assign w_i_p1      = r_i + CW'(1);
    assign w_onehot    = NUM_V'(1) << i_dst[VW-1:0];

    assign o_stat.eval      = w_acc & i_mode;
    assign o_stat.root_end  = (r_root >= r_n);
    assign o_stat.not_white = (w_colour != COL_WHITE);
    assign o_stat.scan_end  = (r_i >= r_n);
    assign o_stat.no_edge   = ~w_row_bit;
    assign o_stat.white     = (w_colour == COL_WHITE);
    assign o_stat.last      = (r_depth == CW'(1));
    assign o_stat.out_busy  = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

    always_comb begin
        n_n         = r_n;
        n_root      = r_root;
        n_depth     = r_depth;
        n_v         = r_v;
        n_i         = r_i;
        n_found     = r_found;
        n_has_cycle = r_has_cycle;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_adj_vld   = r_adj_vld;
        n_col_vld   = r_col_vld;
        adj_we      = 1'b0;
        adj_re      = 1'b0;
        adj_ra      = r_i[VW-1:0];
        col_we      = 1'b0;
        col_wa      = r_i[VW-1:0];
        col_wd      = COL_GREY;
        col_re      = 1'b0;
        col_ra      = r_i[VW-1:0];
        stk_we      = 1'b0;
        stk_wa      = w_depth_m1[VW-1:0];
        stk_wd      = {r_v, w_i_p1};
        stk_re      = 1'b0;
        stk_ra      = w_depth_m2[VW-1:0];

        case (i_ctrl.act)
            ACT_IDLE: begin
                if (w_acc) begin
                    if (i_mode) begin
                        n_n     = CW'(w_cnt_sat);
                        n_root  = '0;
                        n_found = 1'b0;
                    end else if (w_edge_ok) begin
                        adj_we                     = 1'b1;
                        n_adj_vld[i_src[VW-1:0]]   = 1'b1;
                    end
                end
            end
            ACT_ROOT_RD: begin
                col_re = 1'b1;
                col_ra = r_root[VW-1:0];
            end
            ACT_ROOT_OPEN: begin
                n_root = r_root + CW'(1);
                if (o_stat.white) begin
                    col_we                   = 1'b1;
                    col_wa                   = r_root[VW-1:0];
                    col_wd                   = COL_GREY;
                    n_col_vld[r_root[VW-1:0]] = 1'b1;
                    n_v                      = r_root[VW-1:0];
                    n_i                      = '0;
                    n_depth                  = CW'(1);
                    adj_re                   = 1'b1;
                    adj_ra                   = r_root[VW-1:0];
                end
            end
            ACT_SCAN: begin
                if (!o_stat.scan_end) begin
                    if (w_row_bit) begin
                        col_re = 1'b1;
                    end else begin
                        n_i = w_i_p1;
                    end
                end
            end
            ACT_EDGE: begin
                if (o_stat.white) begin
                    // descend: park the current vertex on the stack
                    stk_we                 = 1'b1;
                    col_we                 = 1'b1;
                    col_wd                 = COL_GREY;
                    n_col_vld[r_i[VW-1:0]] = 1'b1;
                    n_v                    = r_i[VW-1:0];
                    n_i                    = '0;
                    n_depth                = r_depth + CW'(1);
                    adj_re                 = 1'b1;
                end else begin
                    if (w_colour == COL_GREY) begin
                        n_found = 1'b1;
                    end
                    n_i = w_i_p1;
                end
            end
            ACT_POP: begin
                col_we          = 1'b1;
                col_wa          = r_v;
                col_wd          = COL_BLACK;
                n_col_vld[r_v]  = 1'b1;
                n_depth         = w_depth_m1;
                stk_re          = ~o_stat.last;
            end
            ACT_RESTORE: begin
                n_v    = r_stk_rd[SW-1:CW];
                n_i    = r_stk_rd[CW-1:0];
                adj_re = 1'b1;
                adj_ra = r_stk_rd[SW-1:CW];
            end
            ACT_DONE: begin
                if (!o_stat.out_busy) begin
                    n_out_valid = 1'b1;
                    n_has_cycle = r_found;
                    n_adj_vld   = '0;
                    n_col_vld   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_adj_vld   <= '0;
            r_col_vld   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_adj_vld   <= n_adj_vld;
            r_col_vld   <= n_col_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_root      <= n_root;
        r_v         <= n_v;
        r_i         <= n_i;
        r_found     <= n_found;
        r_has_cycle <= n_has_cycle;
    end

    // Adjacency memory: first edge of a row writes the whole row
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            if (!r_adj_vld[i_src[VW-1:0]]) begin
                r_adj[i_src[VW-1:0]] <= w_onehot;
            end else begin
                r_adj[i_src[VW-1:0]][i_dst[VW-1:0]] <= 1'b1;
            end
        end
        if (adj_re) begin
            r_adj_rd     <= r_adj[adj_ra];
            r_adj_rd_vld <= r_adj_vld[adj_ra];
        end
    end

    // Colour memory
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col[col_wa] <= col_wd;
        end
        if (col_re) begin
            r_col_rd     <= r_col[col_ra];
            r_col_rd_vld <= r_col_vld[col_ra];
        end
    end

    // Walk stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk[stk_ra];
        end
    end

endmodule

// ===== rtl/directed_graph_cycle_detect.sv =====
// ============================================================================
// directed_graph_cycle_detect
// Cycle detector for a directed graph, depth-first search run by microcode.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_mode i_src i_dst
//                                                  i_vertex_count
//   out      output     o_out_valid / i_out_ready  o_has_cycle
//
// Edge beat (mode 0): sets one adjacency bit when both ids are below the limit.
// Evaluate beat (mode 1): a depth-first search over n = min(vertex_count, limit)
// vertices, the sequencer scanning the neighbors of each vertex entered.
// Hold the input off until the result loads; a pending result delays only that load.
// Reset clears the sequencer, output valid and all row/colour valid bits.
// ============================================================================
module directed_graph_cycle_detect
    import dgcd_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [VERT_W-1:0]  i_src,
    input  logic [VERT_W-1:0]  i_dst,
    input  logic [COUNT_W-1:0] i_vertex_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_has_cycle
);

    // Vertex ids arrive on 6-bit fields, so no more than 64 vertices can
    // carry edges or be searched; size the storage to that.
    localparam int FIELD_SPAN = 1 << VERT_W;
    localparam int NV = (MAX_VERTICES < FIELD_SPAN) ? MAX_VERTICES : FIELD_SPAN;

    t_uword w_ctrl;
    t_stat  w_stat;

    // Sequencer: step counter walking the control store
    dgcd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Datapath: memories, walk registers and output register
    dgcd_dpath #(
        .NUM_V (NV)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_src          (i_src),
        .i_dst          (i_dst),
        .i_vertex_count (i_vertex_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_has_cycle    (o_has_cycle),
        .o_stat         (w_stat)
    );

endmodule

// ===== rtl/dgcd_checker.sv =====
// ============================================================================
// dgcd_checker
// Port-level checks of the cycle detector, bound to the top level.
// ============================================================================
`include "directed_graph_cycle_detect_defines.svh"

module dgcd_checker
    import dgcd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_mode,
    input logic [VERT_W-1:0]  i_src,
    input logic [VERT_W-1:0]  i_dst,
    input logic [COUNT_W-1:0] i_vertex_count,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_has_cycle
);

    logic w_in_acc;
    logic w_edge_acc;
    logic w_eval_acc;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_edge_acc = w_in_acc & ~i_mode & (i_src == i_src) & (i_dst == i_dst);
    assign w_eval_acc = w_in_acc & i_mode & (i_vertex_count == i_vertex_count);

    // A result beat holds until taken
    `DGCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_has_cycle))

    // Reset leaves the block ready with no result pending
    `DGCD_ASSERT_NEXT(a_reset_state, i_clk, 1'b1, !i_rst_n, o_in_ready && !o_out_valid)

    // An edge beat never produces a result
    `DGCD_ASSERT_NEXT(a_edge_silent, i_clk, i_rst_n, w_edge_acc && !o_out_valid, !o_out_valid)

    // An evaluate beat starts the search and holds off the input
    `DGCD_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, w_eval_acc, !o_in_ready)

endmodule

bind directed_graph_cycle_detect dgcd_checker u_dgcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_mode         (i_mode),
    .i_src          (i_src),
    .i_dst          (i_dst),
    .i_vertex_count (i_vertex_count),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_has_cycle    (o_has_cycle)
);
